FILE: rtl/urpe_pkg.sv
// urpe_pkg: constants and sideband types for the unfrozen relative permeability evaluator
// no dependencies; imported by unfrozen_rel_perm_eval

package urpe_pkg;

    localparam int UF_W       = 17;
    localparam int PRESS_W    = 28;
    localparam int KR_W       = 17;
    localparam int HA_CFG_W   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 28;
    localparam int D_W        = 29;
    localparam int NUM_W      = 47;

    localparam logic [KR_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [D_W-1:0]  P0_Q8       = 29'd25939200;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_HALF_ALPHA   = 8;

    localparam logic [HA_CFG_W-1:0]   HALF_ALPHA_RST = 4'd2;
    localparam logic [PRESS_W-1:0]    CUTOFF_RST     = 28'd25600;

    localparam logic [CFG_IDX_W-1:0]  CFG_HALF_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_CUTOFF     = 8'd1;

    // pressure sideband carried through the sine and power stages
    typedef struct packed {
        logic           le;
        logic           ge;
        logic [D_W-1:0] d;
    } side_t;

    // sideband carried through the divider
    typedef struct packed {
        logic            le;
        logic            ge;
        logic [KR_W-1:0] r;
    } tail_t;

endpackage

FILE: rtl/unfrozen_rel_perm_eval.sv
// unfrozen_rel_perm_eval: pipelined relative permeability from unfrozen fraction and pressure
// depends on urpe_pkg (formats, constants, sideband structs)
// stages: address, rom read, interpolate, square, power steps, divider, output register
// throughput: one beat per cycle; every stage advances together when the output is free
// the sine rom, one multiplier per power step and a 17-stage restoring divider set the depth
// reset: synchronous active-low aresetn clears all stage valids, config returns to its defaults

module unfrozen_rel_perm_eval #(
    parameter int SINE_TABLE_DEPTH = urpe_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int MAX_HALF_ALPHA   = urpe_pkg::DEF_MAX_HALF_ALPHA
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [urpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urpe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [urpe_pkg::UF_W-1:0]     s_unfrozen_fraction,
    input  logic [urpe_pkg::PRESS_W-1:0]  s_pressure,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [urpe_pkg::KR_W-1:0]     m_rel_perm
);
    import urpe_pkg::*;

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = UF_W + IDX_W;
    localparam int HA_W   = $clog2(MAX_HALF_ALPHA + 1) + 1;
    localparam int QB     = KR_W;   // quotient bits, one per divider stage

    // taylor term divisors (2k)(2k+1)
    localparam logic [63:0] TAYLOR_DIV [1:15] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
        64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
    };

    typedef logic [KR_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

    // taylor series sine of a q2.30 angle, rounded to q1.16
    function automatic logic [KR_W-1:0] sine_q16(input logic [63:0] t);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (t * t) >> 30;
        term = t;
        sum  = t;
        for (int k = 1; k < 16; k++) begin
            if (term != 0) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k % 2 == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
        end
        sum = (sum + 64'd8192) >> 14;
        if (sum > 64'(ONE_Q16)) begin
            sum = 64'(ONE_Q16);
        end
        return sum[KR_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t        tab;
        logic [63:0] t;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            t = (HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
            tab[i] = sine_q16(t);
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers; the user must write them only while the pipeline is empty (not enforced)
    logic [HA_CFG_W-1:0] half_alpha_reg;
    logic [PRESS_W-1:0]  cutoff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_alpha_reg <= HALF_ALPHA_RST;
            cutoff_reg     <= CUTOFF_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HALF_ALPHA: half_alpha_reg <= cfg_data[HA_CFG_W-1:0];
                CFG_CUTOFF:     cutoff_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective exponent count, clamped to the number of power stages
    logic [HA_W-1:0] ha_eff;
    assign ha_eff = (HA_W'(half_alpha_reg) > HA_W'(MAX_HALF_ALPHA)) ?
                    HA_W'(MAX_HALF_ALPHA) : HA_W'(half_alpha_reg);

    // whole pipeline moves as one when the output register can take a beat
    logic en;
    logic m_valid_reg;
    logic [KR_W-1:0] m_rel_perm_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: clamp fraction, table address, pressure compares
    logic [KR_W-1:0]   uf_c;
    logic [PROD_W-1:0] p_prod;
    logic [D_W-1:0]    top_p;
    logic [D_W-1:0]    h_ext;
    side_t             side1_next;

    assign uf_c   = (s_unfrozen_fraction > ONE_Q16) ? ONE_Q16 : s_unfrozen_fraction;
    assign p_prod = PROD_W'(uf_c) * PROD_W'(SINE_TABLE_DEPTH);
    assign top_p  = P0_Q8 + D_W'(cutoff_reg);
    assign h_ext  = D_W'(s_pressure);

    always_comb begin
        side1_next.le = (h_ext <= P0_Q8);
        side1_next.ge = (h_ext >= top_p);
        side1_next.d  = top_p - h_ext;
    end

    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [15:0]      frac1_reg;
    side_t            side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    // the clamped fraction keeps the index at or below the table depth
    always_ff @(posedge aclk) begin
        if (en) begin
            idx1_reg  <= p_prod[16+IDX_W-1:16];
            frac1_reg <= p_prod[15:0];
            side1_reg <= side1_next;
        end
    end

    // stage 2: registered rom reads of the two neighboring entries
    logic [IDX_W-1:0] idx_b;
    assign idx_b = (idx1_reg >= IDX_W'(SINE_TABLE_DEPTH)) ? idx1_reg : idx1_reg + 1'b1;

    logic            v2_reg;
    logic [KR_W-1:0] a2_reg;
    logic [KR_W-1:0] b2_reg;
    logic [15:0]     frac2_reg;
    side_t           side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg    <= SINE_ROM[idx1_reg];
            b2_reg    <= SINE_ROM[idx_b];
            frac2_reg <= frac1_reg;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: linear interpolation between entries
    logic [KR_W-1:0] diff3;
    logic [33:0]     interp3;
    logic [KR_W-1:0] s3_next;

    assign diff3   = (b2_reg < a2_reg) ? '0 : b2_reg - a2_reg;
    assign interp3 = 34'(diff3) * 34'(frac2_reg) + 34'd32768;
    assign s3_next = a2_reg + interp3[KR_W+15:16];

    logic            v3_reg;
    logic [KR_W-1:0] s3_reg;
    side_t           side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg    <= s3_next;
            side3_reg <= side2_reg;
        end
    end

    // stage 4 (power chain entry): square of the sine, r starts at one
    logic [34:0] sq4;
    assign sq4 = 35'(s3_reg) * 35'(s3_reg) + 35'd32768;

    logic            pw_v_reg    [0:MAX_HALF_ALPHA];
    logic [KR_W-1:0] pw_q_reg    [0:MAX_HALF_ALPHA];
    logic [KR_W-1:0] pw_r_reg    [0:MAX_HALF_ALPHA];
    side_t           pw_side_reg [0:MAX_HALF_ALPHA];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_v_reg[0] <= 1'b0;
        end else if (en) begin
            pw_v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw_q_reg[0]    <= sq4[KR_W+15:16];
            pw_r_reg[0]    <= ONE_Q16;
            pw_side_reg[0] <= side3_reg;
        end
    end

    // power stages: stage k multiplies by q when k is at most the exponent count
    for (genvar k = 1; k <= MAX_HALF_ALPHA; k++) begin : g_pow
        logic [34:0] prod;
        assign prod = 35'(pw_r_reg[k-1]) * 35'(pw_q_reg[k-1]) + 35'd32768;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_v_reg[k] <= 1'b0;
            end else if (en) begin
                pw_v_reg[k] <= pw_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pw_q_reg[k]    <= pw_q_reg[k-1];
                pw_r_reg[k]    <= (HA_W'(k - 1) < ha_eff) ? prod[KR_W+15:16] : pw_r_reg[k-1];
                pw_side_reg[k] <= pw_side_reg[k-1];
            end
        end
    end

    // blend numerator, then one quotient bit per divider stage
    side_t           pw_last;
    logic [KR_W-1:0] r_last;
    logic [NUM_W-1:0] num_next;

    assign pw_last  = pw_side_reg[MAX_HALF_ALPHA];
    assign r_last   = pw_r_reg[MAX_HALF_ALPHA];
    assign num_next = NUM_W'(ONE_Q16 - r_last) * NUM_W'(pw_last.d)
                    + NUM_W'(cutoff_reg >> 1);

    logic             dv_v_reg    [0:QB];
    logic [NUM_W-1:0] dv_rem_reg  [0:QB];
    logic [QB-1:0]    dv_quo_reg  [0:QB];
    tail_t            dv_tail_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= pw_v_reg[MAX_HALF_ALPHA];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]     <= num_next;
            dv_quo_reg[0]     <= '0;
            dv_tail_reg[0].le <= pw_last.le;
            dv_tail_reg[0].ge <= pw_last.ge;
            dv_tail_reg[0].r  <= r_last;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [NUM_W-1:0] dsh;
        logic             fits;
        assign dsh  = NUM_W'(cutoff_reg) << (QB - j);
        assign fits = (dv_rem_reg[j-1] >= dsh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j]  <= fits ? dv_rem_reg[j-1] - dsh : dv_rem_reg[j-1];
                dv_quo_reg[j]  <= dv_quo_reg[j-1] | (QB'(fits) << (QB - j));
                dv_tail_reg[j] <= dv_tail_reg[j-1];
            end
        end
    end

    // final select and saturation into the output register
    tail_t           tl;
    logic [KR_W:0]   blend;
    logic [KR_W-1:0] kr_next;

    assign tl    = dv_tail_reg[QB];
    assign blend = (KR_W+1)'(tl.r) + (KR_W+1)'(dv_quo_reg[QB]);

    always_comb begin
        if (tl.le) begin
            kr_next = ONE_Q16;
        end else if (tl.ge) begin
            kr_next = tl.r;
        end else if (blend > (KR_W+1)'(ONE_Q16)) begin
            kr_next = ONE_Q16;
        end else begin
            kr_next = blend[KR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_rel_perm_reg <= kr_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_rel_perm = m_rel_perm_reg;

    // front-end stage valids, used by the stall check
    logic [3:0] front_v;
    assign front_v = {v1_reg, v2_reg, v3_reg, pw_v_reg[0]};

    a_kr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_rel_perm_reg <= ONE_Q16))
        else $error("rel_perm above one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(front_v) && $stable(dv_v_reg[QB]))
        else $error("stage valids moved during stall");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !v1_reg)
        else $error("valids not cleared by reset");

endmodule
